// File: hw/rtl/bsu_pkg.sv
package bsu_pkg;

   // uart register address on the bus
   localparam logic [7:0] UART_ADDR = 8'hFC;

   // frame sizes
   localparam int TX_BITS = 11;
   localparam int RX_BITS = 10;

   localparam logic [3:0] TX_LAST = 4'(TX_BITS);
   localparam logic [3:0] RX_LAST = 4'(RX_BITS);

   // register indexes on the csr port
   localparam logic [1:0] REG_BAUD_DIVISOR = 2'd0;

   localparam logic [15:0] BAUD_DIVISOR_RESET = 16'd868;

   // one bus/line sample per item
   typedef struct packed {
      logic [7:0] bus_address;
      logic       write_enable;
      logic       bus_cycle;
      logic       bus_strobe;
      logic [7:0] write_byte;
      logic       rx_level;
   } sample_type;

endpackage

// File: hw/rtl/bsu_engine.sv
module bsu_engine
   import bsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  sample_type       sample,
   input  logic [15:0]      baud_divisor,
   output logic             tx_level,
   output logic             bus_ack,
   output logic [RX_BITS-1:0] rx_frame
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WRITE,
      PH_READ_WAIT,
      PH_READ
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [15:0]        countdown_ff, countdown_in;
   logic [3:0]         tx_index_ff, tx_index_in;
   logic [3:0]         rx_index_ff, rx_index_in;
   logic [TX_BITS-1:0] tx_shift_ff, tx_shift_in;
   logic [RX_BITS-1:0] rx_shift_ff, rx_shift_in;
   logic               tx_hold_ff, tx_hold_in;
   logic               ack_ff, ack_in;

   logic [15:0] reload;
   logic        hit;
   logic        tick;
   logic [3:0]  tx_index_inc;
   logic [3:0]  rx_index_inc;

   assign reload       = baud_divisor - 16'd1;
   assign hit          = (sample.bus_address == UART_ADDR) && sample.bus_strobe
                         && sample.bus_cycle;
   assign tick         = (countdown_ff == 16'd1);
   assign tx_index_inc = tx_index_ff + 4'd1;
   assign rx_index_inc = rx_index_ff + 4'd1;

   // one step of the uart sequencer
   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      tx_index_in  = tx_index_ff;
      rx_index_in  = rx_index_ff;
      tx_shift_in  = tx_shift_ff;
      rx_shift_in  = rx_shift_ff;
      tx_hold_in   = tx_hold_ff;
      ack_in       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            tx_hold_in   = 1'b1;
            tx_index_in  = 4'd0;
            rx_index_in  = 4'd1;
            countdown_in = reload;
            phase_in     = PH_IDLE;
            if (hit) begin
               if (sample.write_enable) begin
                  tx_shift_in = {2'b11, sample.write_byte, 1'b0};
                  tx_hold_in  = 1'b0;
                  tx_index_in = 4'd1;
                  phase_in    = PH_WRITE;
               end else begin
                  phase_in = PH_READ_WAIT;
               end
            end
         end
         PH_WRITE: begin
            if (tick) begin
               if (tx_index_ff < TX_LAST) begin
                  tx_hold_in = tx_shift_ff[tx_index_ff];
               end
               countdown_in = reload;
               tx_index_in  = tx_index_inc;
               if (tx_index_inc >= TX_LAST) begin
                  phase_in    = PH_IDLE;
                  ack_in      = 1'b1;
                  tx_index_in = 4'd0;
               end
            end else begin
               countdown_in = countdown_ff - 16'd1;
            end
         end
         PH_READ_WAIT: begin
            // start bit must already be low, else give up
            if (!sample.rx_level) begin
               rx_shift_in[0] = 1'b0;
               phase_in       = PH_READ;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_READ: begin
            if (tick) begin
               if (rx_index_ff < RX_LAST) begin
                  rx_shift_in[rx_index_ff] = sample.rx_level;
               end
               countdown_in = reload;
               rx_index_in  = rx_index_inc;
               if (rx_index_inc >= RX_LAST) begin
                  phase_in    = PH_IDLE;
                  rx_index_in = 4'd1;
                  ack_in      = 1'b1;
               end
            end else begin
               countdown_in = countdown_ff - 16'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // state and result registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         countdown_ff <= BAUD_DIVISOR_RESET - 16'd1;
         tx_index_ff  <= 4'd0;
         rx_index_ff  <= 4'd1;
         tx_shift_ff  <= '0;
         rx_shift_ff  <= '0;
         tx_hold_ff   <= 1'b1;
         ack_ff       <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         tx_index_ff  <= tx_index_in;
         rx_index_ff  <= rx_index_in;
         tx_shift_ff  <= tx_shift_in;
         rx_shift_ff  <= rx_shift_in;
         tx_hold_ff   <= tx_hold_in;
         ack_ff       <= ack_in;
      end
   end

   assign tx_level = tx_hold_ff;
   assign bus_ack  = ack_ff;
   assign rx_frame = rx_shift_ff;

endmodule

// File: hw/rtl/bus_slave_uart_half_duplex_core.sv
// Bus slave with a half-duplex 8N2 uart.
// Each req_ item is one clock cycle of bus signals plus the rx line sample.
// Each accepted item yields exactly one rsp_ item: tx line level, bus_ack
// and the received 10-bit frame (bit0 start, bits 8..1 data, bit9 stop).
// A strobed write to 0xFC sends write_byte as start, 8 data LSB first and
// two stop bits, each bit held baud_divisor minus one items; ack pulses as
// the frame ends. A strobed read to 0xFC receives if rx is low on the next
// item, sampling nine more bits on baud ticks, then pulses ack.
// The result for an item is on rsp_ in the cycle after acceptance.
// Throughput: one item per cycle while the result slot is free or taken;
// sequencer state and result register update together in one register stage.
// When the receiver stalls, the result register holds and req_ready drops
// once it is full; req_ready is high whenever the result slot is empty or
// being taken in the same cycle.
// Reset: sequencer idle, tx high, frame zero, baud_divisor back to 868, no
// result pending. baud_divisor is written at byte address 0 over the csr port.
module bus_slave_uart_half_duplex_core
   import bsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_bus_address,
   input  logic        req_write_enable,
   input  logic        req_bus_cycle,
   input  logic        req_bus_strobe,
   input  logic [7:0]  req_write_byte,
   input  logic        req_rx_level,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_level,
   output logic        rsp_bus_ack,
   output logic [9:0]  rsp_rx_frame,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] divisor_ff;
   logic        accept;
   logic        csr_write;
   sample_type  sample;

   // csr port, single register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr == REG_BAUD_DIVISOR) ? {16'd0, divisor_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= BAUD_DIVISOR_RESET;
      end else if (csr_write && paddr == REG_BAUD_DIVISOR) begin
         divisor_ff <= pwdata[15:0];
      end
   end

   // handshake: result register frees when taken
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sample.bus_address  = req_bus_address;
   assign sample.write_enable = req_write_enable;
   assign sample.bus_cycle    = req_bus_cycle;
   assign sample.bus_strobe   = req_bus_strobe;
   assign sample.write_byte   = req_write_byte;
   assign sample.rx_level     = req_rx_level;

   bsu_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .sample       (sample),
      .baud_divisor (divisor_ff),
      .tx_level     (rsp_tx_level),
      .bus_ack      (rsp_bus_ack),
      .rx_frame     (rsp_rx_frame)
   );

endmodule
